@@ src/b64e_pkg.sv @@
// shared types, constants and the character table for the base64 encoder
`default_nettype none
package b64e_pkg;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // padding character
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // one job: the characters a single input byte produces
  typedef struct packed {
    logic [3:0][6:0] chars;   // character k in chars[k]
    logic [1:0]      cnt_m1;  // number of characters minus one
    logic            last;    // final character of the job ends the message
  } job_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] ch;
    if (idx < 6'd26) begin
      ch = 7'(7'h41 + {1'b0, idx});
    end else if (idx < 6'd52) begin
      ch = 7'(7'h61 + {1'b0, idx} - 7'd26);
    end else if (idx < 6'd62) begin
      ch = 7'(7'h30 + {1'b0, idx} - 7'd52);
    end else if (idx == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ src/b64e_front.sv @@
// front part: tracks the group position and turns each byte into a job
`default_nettype none
module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output job_t            job
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  // character selection for the current group position
  always_comb begin
    job       = '0;
    job.last  = last_byte;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    case (phase_r)
      PH_SECOND: begin
        // only the low two carry bits reach the 6-bit index
        job.chars[0] = b64_char({carry_r[1:0], data_byte[7:4]});
        carry_nxt    = data_byte[3:0];
        phase_nxt    = PH_THIRD;
        if (last_byte) begin
          job.chars[1] = b64_char({data_byte[3:0], 2'b00});
          job.chars[2] = PAD_CHAR;
          job.cnt_m1   = 2'd2;
        end else begin
          job.cnt_m1   = 2'd0;
        end
      end
      PH_THIRD: begin
        job.chars[0] = b64_char({carry_r, data_byte[7:6]});
        job.chars[1] = b64_char(data_byte[5:0]);
        job.cnt_m1   = 2'd1;
        carry_nxt    = 4'd0;
        phase_nxt    = PH_FIRST;
      end
      default: begin
        // first byte of a group, also the unused phase code
        job.chars[0] = b64_char(data_byte[7:2]);
        carry_nxt    = {2'b00, data_byte[1:0]};
        phase_nxt    = PH_SECOND;
        if (last_byte) begin
          job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
          job.chars[2] = PAD_CHAR;
          job.chars[3] = PAD_CHAR;
          job.cnt_m1   = 2'd3;
        end else begin
          job.cnt_m1   = 2'd0;
        end
      end
    endcase
    // message end restarts the group
    if (last_byte) begin
      phase_nxt = PH_FIRST;
      carry_nxt = 4'd0;
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // a final byte leaves a clean group start
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> phase_r == PH_FIRST && carry_r == 4'd0)
    else $error("group state not cleared after final byte");

endmodule
`default_nettype wire

@@ src/b64e_queue.sv @@
// short job queue between the front and the back part
`default_nettype none
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("job queue overfilled");

endmodule
`default_nettype wire

@@ src/b64e_back.sv @@
// back part: serialises queued jobs into one character per beat
`default_nettype none
module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire job_t       q_head,
  output logic            q_pop,
  output logic            out_valid,
  output logic [6:0]      out_char,
  output logic            out_last,
  input  wire logic       out_ready
);

  job_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] pos_r;
  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_last_r;
  logic       load_out, finish;

  // next character moves into the output register when it is free
  assign load_out = cur_valid_r && (!out_valid_r || out_ready);
  assign finish   = load_out && (pos_r == cur_r.cnt_m1);
  assign q_pop    = q_valid && (!cur_valid_r || finish);

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // current job and character position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= 2'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      pos_r       <= 2'd0;
    end else if (finish) begin
      cur_valid_r <= 1'b0;
    end else if (load_out) begin
      pos_r <= 2'(pos_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= cur_r.chars[pos_r];
      out_last_r <= cur_r.last && (pos_r == cur_r.cnt_m1);
    end
  end

  a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> pos_r <= cur_r.cnt_m1)
    else $error("character position beyond job length");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && cur_r.last && pos_r == cur_r.cnt_m1 |=> !cur_valid_r || $past(q_pop))
    else $error("job still open after final character");

endmodule
`default_nettype wire

@@ src/base64_stream_encoder.sv @@
// Streaming base64 encoder (standard alphabet, '=' padding). One raw byte
// per input beat, tlast on the final byte of a message; one ASCII character
// per output beat, tlast on the final character. A byte gives one or two
// characters mid-stream and up to four on the final byte. The front part
// takes a byte every cycle while the job queue has room; the back part emits
// one character per cycle while out_tready is high and jobs are queued, and
// the output character register sets the sustained rate. An accepted byte
// passes through the job queue, the current-job register and the output
// character register before its first character appears.
`default_nettype none
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] out_char, [7] zero
  output logic            out_tlast   // last_char
);

  job_t       front_job, q_head;
  logic       q_full, q_valid, q_pop, in_accept;
  logic [6:0] out_char;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;
  assign out_tdata = {1'b0, out_char};

  // byte classification and group tracking
  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .job       (front_job)
  );

  // decoupling queue
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // character serialiser
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule
`default_nettype wire

@@ bench/tb_base64_stream_encoder.sv @@
`timescale 1ns / 100ps
// testbench for the base64 stream encoder: byte messages in, characters checked against a predictor
module tb_base64_stream_encoder;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;

  // position of the next byte within its 3-byte group
  localparam logic [1:0] GRP_FIRST  = 2'd0;
  localparam logic [1:0] GRP_SECOND = 2'd1;
  localparam logic [1:0] GRP_THIRD  = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] data_byte
  logic       in_tlast   = 1'b0;   // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [6:0] out_char, [7] zero
  logic       out_tlast;           // last_char

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  raw_byte_t  pending_bytes[$];
  enc_char_t  expected_chars[$];

  // predictor state
  logic [1:0] grp_pos   = GRP_FIRST;
  logic [3:0] carry_nib = 4'h0;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int send_gap  = 0;
  int recv_gap  = 0;
  int chars_seen = 0;
  int err_cnt    = 0;
  int quiet_cycles = 0;

  base64_stream_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] sextet_char(input logic [5:0] idx);
    return 7'(alphabet[idx]);
  endfunction

  // characters one accepted byte completes, appended to the expected list
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (grp_pos)
      GRP_SECOND: begin
        expected_chars.push_back({sextet_char({carry_nib[1:0], b[7:4]}), 1'b0});
        if (fin) begin
          expected_chars.push_back({sextet_char({b[3:0], 2'b00}), 1'b0});
          expected_chars.push_back({b64e_pkg::PAD_CHAR, 1'b1});
        end
        carry_nib = b[3:0];
        grp_pos   = GRP_THIRD;
      end
      GRP_THIRD: begin
        expected_chars.push_back({sextet_char({carry_nib, b[7:6]}), 1'b0});
        expected_chars.push_back({sextet_char(b[5:0]), fin});
        carry_nib = 4'h0;
        grp_pos   = GRP_FIRST;
      end
      default: begin
        // unused phase value behaves as the start of a group
        expected_chars.push_back({sextet_char(b[7:2]), 1'b0});
        if (fin) begin
          expected_chars.push_back({sextet_char({b[1:0], 4'h0}), 1'b0});
          expected_chars.push_back({b64e_pkg::PAD_CHAR, 1'b0});
          expected_chars.push_back({b64e_pkg::PAD_CHAR, 1'b1});
        end
        carry_nib = {2'b00, b[1:0]};
        grp_pos   = GRP_SECOND;
      end
    endcase
    if (fin) begin
      grp_pos   = GRP_FIRST;
      carry_nib = 4'h0;
    end
  endtask

  // byte driver fed from the pending queue
  always @(posedge clk) begin
    raw_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
          send_gap  <= send_idle ? $urandom_range(0, 8) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // character monitor with random back-pressure and two long hold-offs
  always @(posedge clk) begin
    enc_char_t exp_c;
    int        stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
    end else begin
      stall = recv_gap;
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat: out_tdata=%h out_tlast=%b", out_tdata, out_tlast);
          err_cnt++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (out_tdata[6:0] !== exp_c.ch) begin
            $error("out_char mismatch: expected %h, actual %h", exp_c.ch, out_tdata[6:0]);
            err_cnt++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $error("out_tdata[7] mismatch: expected 0, actual %b", out_tdata[7]);
            err_cnt++;
          end
          if (out_tlast !== exp_c.last) begin
            $error("last_char mismatch: expected %b, actual %b", exp_c.last, out_tlast);
            err_cnt++;
          end
        end
        chars_seen++;
        stall = recv_idle ? $urandom_range(0, 8) : 0;
        if (chars_seen == 150 || chars_seen == 700) begin
          stall = HOLD_CYCLES;
        end
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        recv_gap   <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        recv_gap   <= 0;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    pending_bytes.push_back({b, fin});
  endtask

  task automatic queue_message(input int len);
    for (int k = 0; k < len; k++) begin
      queue_byte(8'($urandom_range(0, 255)), k == len - 1);
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_tvalid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // random messages, mostly short with some long ones
  task automatic run_phase(input int n_bytes, input bit s_idle, input bit r_idle);
    int queued;
    int len;
    queued    = 0;
    send_idle = s_idle;
    recv_idle = r_idle;
    while (queued < n_bytes) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      queue_message(len);
      queued += len;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: last byte at each group position, extreme bytes, '+' and '/'
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7F, 1'b1);
    drain();

    run_phase(150, 1'b1, 1'b1);
    run_phase(100, 1'b0, 1'b0);
    run_phase(120, 1'b1, 1'b0);
    run_phase(130, 1'b0, 1'b1);

    // let any late beat show up
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
bench/tb_base64_stream_encoder.sv
